[rtl/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and helpers for the triangle plane clipper.
// ----------------------------------------------------------------------------
package tpc_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned DistWidth  = 64;
   localparam int unsigned WeightWidth = 16;
   localparam int unsigned DivSteps   = 16;

   localparam logic signed [DistWidth-1:0] FarEnough = 64'sd42926080;
   localparam logic signed [DistWidth-1:0] NearBelow = -64'sd65536;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DistWidth-1:0] dist_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      vec_type n;
      vec_type v0;
      vec_type v1;
      vec_type v2;
   } tri_type;

   typedef struct packed {
      coord_type  vert_x;
      coord_type  vert_y;
      coord_type  vert_z;
      logic [2:0] vertex_count;
      logic [1:0] vertex_slot;
      logic       present;
      logic       last;
   } vert_type;

   typedef enum logic [1:0] {
      MODE_EMPTY = 2'd0,
      MODE_PASS  = 2'd1,
      MODE_QUAD  = 2'd2,
      MODE_TRI   = 2'd3
   } mode_type;

   function automatic dist_type add_sat(input dist_type a, input dist_type b);
      dist_type s;
      s = a + b;
      if (a[DistWidth-1] == b[DistWidth-1] && s[DistWidth-1] != a[DistWidth-1]) begin
         s = a[DistWidth-1] ? {1'b1, {(DistWidth-1){1'b0}}} : {1'b0, {(DistWidth-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

[rtl/tpc_if.sv]
// ----------------------------------------------------------------------------
// tpc_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface tpc_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/tpc_dist.sv]
// ----------------------------------------------------------------------------
// tpc_dist
// Plane distance unit: products registered, then saturating sum.
// ----------------------------------------------------------------------------
module tpc_dist (
   input  logic            clock,
   input  logic            enable,
   input  tpc_pkg::vec_type v,
   input  tpc_pkg::vec_type n,
   output tpc_pkg::dist_type d
);
   import tpc_pkg::*;

   dist_type px_ff, py_ff, pz_ff, d_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         px_ff <= DistWidth'(v.x * n.x);
         py_ff <= DistWidth'(v.y * n.y);
         pz_ff <= DistWidth'(v.z * n.z);
         d_ff  <= add_sat(add_sat(px_ff, py_ff), pz_ff);
      end
   end

   assign d = d_ff;
endmodule

[rtl/tpc_div.sv]
// ----------------------------------------------------------------------------
// tpc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tpc_div (
   input  logic                                clock,
   input  logic                                enable,
   input  tpc_pkg::dist_type                   da,
   input  tpc_pkg::dist_type                   db,
   output logic [tpc_pkg::WeightWidth-1:0]     w
);
   import tpc_pkg::*;

   logic [DistWidth-1:0]   r_ff   [DivSteps+1];
   logic [DistWidth-1:0]   den_ff [DivSteps+1];
   logic [WeightWidth-1:0] q_ff   [DivSteps+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0]   <= da;
         den_ff[0] <= da - db;
         q_ff[0]   <= '0;
         for (int i = 0; i < DivSteps; i++) begin
            logic [DistWidth-1:0] rs;
            rs = {r_ff[i][DistWidth-2:0], 1'b0};
            den_ff[i+1] <= den_ff[i];
            if (r_ff[i][DistWidth-1] || rs >= den_ff[i]) begin
               r_ff[i+1] <= rs - den_ff[i];
               q_ff[i+1] <= {q_ff[i][WeightWidth-2:0], 1'b1};
            end else begin
               r_ff[i+1] <= rs;
               q_ff[i+1] <= {q_ff[i][WeightWidth-2:0], 1'b0};
            end
         end
      end
   end

   assign w = q_ff[DivSteps];
endmodule

[rtl/tpc_mix.sv]
// ----------------------------------------------------------------------------
// tpc_mix
// Lerp of two vectors by a Q0.16 weight, products registered.
// ----------------------------------------------------------------------------
module tpc_mix (
   input  logic                            clock,
   input  logic                            enable,
   input  tpc_pkg::vec_type                a,
   input  tpc_pkg::vec_type                b,
   input  logic [tpc_pkg::WeightWidth-1:0] w,
   output tpc_pkg::vec_type                m
);
   import tpc_pkg::*;

   localparam int unsigned PW = CoordWidth + WeightWidth + 2;
   logic signed [PW-1:0] pa_ff [3];
   logic signed [PW-1:0] pb_ff [3];
   vec_type m_ff;
   coord_type ca [3], cb [3];
   logic signed [PW-1:0] s [3];

   assign ca[0] = a.x; assign ca[1] = a.y; assign ca[2] = a.z;
   assign cb[0] = b.x; assign cb[1] = b.y; assign cb[2] = b.z;

   always_comb begin
      for (int i = 0; i < 3; i++) s[i] = pa_ff[i] + pb_ff[i];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= PW'(ca[i] * $signed({2'b0, ~w} + 18'd1));
            pb_ff[i] <= PW'(cb[i] * $signed({2'b0, w}));
         end
         m_ff.x <= s[0][WeightWidth +: CoordWidth];
         m_ff.y <= s[1][WeightWidth +: CoordWidth];
         m_ff.z <= s[2][WeightWidth +: CoordWidth];
      end
   end

   assign m = m_ff;
endmodule

[rtl/tpc_emit.sv]
// ----------------------------------------------------------------------------
// tpc_emit
// Output serializer: holds one polygon and sends its vertices in order.
// ----------------------------------------------------------------------------
module tpc_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tpc_pkg::mode_type     mode,
   input  tpc_pkg::vec_type      p [4],
   tpc_if.source                 rsp
);
   import tpc_pkg::*;

   logic       full_ff, full_in;
   logic [1:0] slot_ff, slot_in;
   mode_type   mode_ff;
   vec_type    p_ff [4];
   logic [1:0] last_slot;
   logic [2:0] cnt;
   logic       done;

   always_comb begin
      case (mode_ff)
         MODE_EMPTY: begin last_slot = 2'd0; cnt = 3'd0; end
         MODE_QUAD:  begin last_slot = 2'd3; cnt = 3'd4; end
         default:    begin last_slot = 2'd2; cnt = 3'd3; end
      endcase
   end

   assign done     = rsp.valid && rsp.ready && slot_ff == last_slot;
   assign in_ready = !full_ff || done;
   assign rsp.valid = full_ff;

   always_comb begin
      rsp.data.vert_x       = p_ff[slot_ff].x;
      rsp.data.vert_y       = p_ff[slot_ff].y;
      rsp.data.vert_z       = p_ff[slot_ff].z;
      rsp.data.vertex_count = cnt;
      rsp.data.vertex_slot  = slot_ff;
      rsp.data.present      = mode_ff != MODE_EMPTY;
      rsp.data.last         = slot_ff == last_slot;
      if (mode_ff == MODE_EMPTY) begin
         rsp.data.vert_x = '0; rsp.data.vert_y = '0; rsp.data.vert_z = '0;
      end
   end

   always_comb begin
      full_in = full_ff;
      slot_in = slot_ff;
      if (rsp.valid && rsp.ready) slot_in = slot_ff + 2'd1;
      if (done) full_in = 1'b0;
      if (in_valid && in_ready) begin
         full_in = 1'b1;
         slot_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         slot_ff <= 2'd0;
      end else begin
         full_ff <= full_in;
         slot_ff <= slot_in;
      end
      if (in_valid && in_ready) begin
         mode_ff <= mode;
         for (int i = 0; i < 4; i++) p_ff[i] <= p[i];
      end
   end
endmodule

[rtl/triangle_plane_clipper_core.sv]
// ----------------------------------------------------------------------------
// triangle_plane_clipper_core
// Clips a triangle against a plane through the origin.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one triangle transaction: plane normal and three vertices,
//   signed Q16.16. rsp carries the clipped polygon one vertex per
//   transaction, last set on the final one; a fully clipped triangle gives
//   one transaction with present low.
//   The request passes through distance products and sum, classify into the
//   divider load stage, 16 weight divider steps, lerp products and sum,
//   then the output serializer.
//   One triangle per cycle enters the pipe while it is not stalled; the output
//   serializer drains 1 to 4 vertex transactions per triangle, so it sets
//   the sustained triangle rate.
//   The whole pipe advances only when its last stage is empty or can hand over
//   to the serializer; a stalled rsp with a full last stage freezes every stage, nothing lost.
//   Reset clears the stage valid bits and the serializer.
// ----------------------------------------------------------------------------
module triangle_plane_clipper_core (
   input  logic  clock,
   input  logic  reset,
   tpc_if.sink   req,
   tpc_if.source rsp
);
   import tpc_pkg::*;

   localparam int unsigned Depth = 2 + 1 + DivSteps + 2;

   localparam int unsigned CS = 2;
   localparam int unsigned MS = CS + 1 + DivSteps;

   logic    en, e_ready;
   logic    vld_ff [Depth];
   tri_type t_ff [CS];
   dist_type d0, d1, d2;
   mode_type mode_ff [Depth];
   vec_type  q0_ff [Depth], q1_ff [Depth], q2_ff [Depth];
   mode_type mode_c;
   vec_type  q0_c, q1_c, q2_c;
   dist_type e0_c, e1_c, e2_c;
   logic [WeightWidth-1:0] wa, wb;
   vec_type  ma, mb;
   vec_type  pout [4];

   assign en = !vld_ff[Depth-1] || e_ready;
   assign req.ready = en;

   tpc_dist u_d0 (.clock, .enable(en), .v(req.data.v0), .n(req.data.n), .d(d0));
   tpc_dist u_d1 (.clock, .enable(en), .v(req.data.v1), .n(req.data.n), .d(d1));
   tpc_dist u_d2 (.clock, .enable(en), .v(req.data.v2), .n(req.data.n), .d(d2));

   always_comb begin
      logic a0, a1, a2, nxt;
      tri_type t;
      t  = t_ff[CS-1];
      a0 = !d0[DistWidth-1]; a1 = !d1[DistWidth-1]; a2 = !d2[DistWidth-1];
      if (a1 && !a0) begin
         nxt = a2; q0_c = t.v1; q1_c = t.v2; q2_c = t.v0; e0_c = d1; e1_c = d2; e2_c = d0;
      end else if (a2 && !a1) begin
         nxt = a0; q0_c = t.v2; q1_c = t.v0; q2_c = t.v1; e0_c = d2; e1_c = d0; e2_c = d1;
      end else begin
         nxt = a1; q0_c = t.v0; q1_c = t.v1; q2_c = t.v2; e0_c = d0; e1_c = d1; e2_c = d2;
      end
      if (d0 < FarEnough && d1 < FarEnough && d2 < FarEnough) mode_c = MODE_EMPTY;
      else if (d0 >= NearBelow && d1 >= NearBelow && d2 >= NearBelow) begin
         mode_c = MODE_PASS; q0_c = t.v0; q1_c = t.v1; q2_c = t.v2;
      end else mode_c = nxt ? MODE_QUAD : MODE_TRI;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < Depth; i++) vld_ff[i] <= vld_ff[i-1];
      end
      if (en) begin
         t_ff[0] <= req.data;
         for (int i = 1; i < CS; i++) t_ff[i] <= t_ff[i-1];
         mode_ff[CS] <= mode_c;
         q0_ff[CS] <= q0_c; q1_ff[CS] <= q1_c; q2_ff[CS] <= q2_c;
         for (int i = CS + 1; i < Depth; i++) begin
            mode_ff[i] <= mode_ff[i-1];
            q0_ff[i] <= q0_ff[i-1]; q1_ff[i] <= q1_ff[i-1]; q2_ff[i] <= q2_ff[i-1];
         end
      end
   end

   // quad: mix(q1,q2) and mix(q0,q2); tri: mix(q0,q1) and mix(q0,q2)
   tpc_div u_wa (.clock, .enable(en),
      .da(mode_c == MODE_QUAD ? e1_c : e0_c), .db(mode_c == MODE_QUAD ? e2_c : e1_c), .w(wa));
   tpc_div u_wb (.clock, .enable(en), .da(e0_c), .db(e2_c), .w(wb));

   tpc_mix u_ma (.clock, .enable(en),
      .a(mode_ff[MS-1] == MODE_QUAD ? q1_ff[MS-1] : q0_ff[MS-1]),
      .b(mode_ff[MS-1] == MODE_QUAD ? q2_ff[MS-1] : q1_ff[MS-1]), .w(wa), .m(ma));
   tpc_mix u_mb (.clock, .enable(en), .a(q0_ff[MS-1]), .b(q2_ff[MS-1]), .w(wb), .m(mb));

   always_comb begin
      pout[0] = q0_ff[Depth-1];
      pout[1] = q1_ff[Depth-1];
      pout[2] = q2_ff[Depth-1];
      pout[3] = mb;
      case (mode_ff[Depth-1])
         MODE_QUAD: pout[2] = ma;
         MODE_TRI:  begin pout[1] = ma; pout[2] = mb; end
         default:   pout[3] = mb;
      endcase
   end

   tpc_emit u_emit (.clock, .reset, .in_valid(vld_ff[Depth-1]), .in_ready(e_ready),
      .mode(mode_ff[Depth-1]), .p(pout), .rsp);
endmodule

[rtl/tpc_checker.sv]
// ----------------------------------------------------------------------------
// tpc_checker
// Port-level checks for the triangle plane clipper.
// ----------------------------------------------------------------------------
module tpc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input tpc_pkg::vert_type rsp_data
);
   import tpc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed under stall");

   a_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         !rsp_valid || rsp_data.vertex_slot == $past(rsp_data.vertex_slot) + 2'd1)
      else $error("slot sequence broken");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.present |-> rsp_data.last && rsp_data.vertex_count == 3'd0)
      else $error("empty result malformed");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.present |->
         rsp_data.last == (3'(rsp_data.vertex_slot) + 3'd1 == rsp_data.vertex_count))
      else $error("last flag mismatch");
endmodule

bind triangle_plane_clipper_core tpc_checker u_checker (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

[dv/tpc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpc_monitor
// Watches the triangle and vertex channels, predicts the clipped polygon
// for every accepted triangle and compares each vertex transaction with it.
// ----------------------------------------------------------------------------
module tpc_monitor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tpc_pkg::tri_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tpc_pkg::vert_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import tpc_pkg::*;

   vert_type expected_verts[$];

   function automatic longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if ((a < 0) == (b < 0) && (s < 0) != (a < 0))
         s = (a < 0) ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
      return s;
   endfunction

   function automatic longint plane_dist(vec_type v, vec_type n);
      longint s;
      longint p;
      p = longint'(v.x) * longint'(n.x);
      s = p;
      p = longint'(v.y) * longint'(n.y);
      s = sat_add(s, p);
      p = longint'(v.z) * longint'(n.z);
      return sat_add(s, p);
   endfunction

   function automatic logic [15:0] lerp_weight(longint da, longint db);
      logic [63:0] num, den, r;
      logic [15:0] q;
      logic        carry;
      num = da;
      den = num + (64'd0 - 64'(db));
      r = num;
      q = '0;
      for (int i = 0; i < 16; i++) begin
         carry = r[63];
         r = r << 1;
         q = q << 1;
         if (carry || r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic coord_type lerp_coord(coord_type a, coord_type b, logic [15:0] w);
      longint s;
      s = longint'(a) * (65536 - longint'({1'b0, w})) + longint'(b) * longint'({1'b0, w});
      s = s >>> 16;
      return coord_type'(s[31:0]);
   endfunction

   function automatic vec_type lerp_vec(vec_type a, vec_type b, logic [15:0] w);
      vec_type r;
      r.x = lerp_coord(a.x, b.x, w);
      r.y = lerp_coord(a.y, b.y, w);
      r.z = lerp_coord(a.z, b.z, w);
      return r;
   endfunction

   task automatic push_vert(vec_type v, int cnt, int slot, logic is_last);
      vert_type e;
      e.vert_x = v.x;
      e.vert_y = v.y;
      e.vert_z = v.z;
      e.vertex_count = 3'(cnt);
      e.vertex_slot = 2'(slot);
      e.present = 1'b1;
      e.last = is_last;
      expected_verts.insert(expected_verts.size(), e);
   endtask

   task automatic clip_triangle(tri_type t);
      longint d[3];
      longint e0, e1, e2;
      vec_type v[3];
      vec_type p0, p1, p2;
      logic a0, a1, a2, next_above;
      vert_type e;
      v[0] = t.v0;
      v[1] = t.v1;
      v[2] = t.v2;
      for (int i = 0; i < 3; i++) d[i] = plane_dist(v[i], t.n);
      if (d[0] < FarEnough && d[1] < FarEnough && d[2] < FarEnough) begin
         e = '0;
         e.last = 1'b1;
         expected_verts.insert(expected_verts.size(), e);
      end else if (d[0] >= NearBelow && d[1] >= NearBelow && d[2] >= NearBelow) begin
         for (int i = 0; i < 3; i++) push_vert(v[i], 3, i, i == 2);
      end else begin
         a0 = d[0] >= 0;
         a1 = d[1] >= 0;
         a2 = d[2] >= 0;
         if (a1 && !a0) begin
            next_above = a2;
            p0 = v[1]; p1 = v[2]; p2 = v[0];
            e0 = d[1]; e1 = d[2]; e2 = d[0];
         end else if (a2 && !a1) begin
            next_above = a0;
            p0 = v[2]; p1 = v[0]; p2 = v[1];
            e0 = d[2]; e1 = d[0]; e2 = d[1];
         end else begin
            next_above = a1;
            p0 = v[0]; p1 = v[1]; p2 = v[2];
            e0 = d[0]; e1 = d[1]; e2 = d[2];
         end
         if (next_above) begin
            push_vert(p0, 4, 0, 1'b0);
            push_vert(p1, 4, 1, 1'b0);
            push_vert(lerp_vec(p1, p2, lerp_weight(e1, e2)), 4, 2, 1'b0);
            push_vert(lerp_vec(p0, p2, lerp_weight(e0, e2)), 4, 3, 1'b1);
         end else begin
            push_vert(p0, 3, 0, 1'b0);
            push_vert(lerp_vec(p0, p1, lerp_weight(e0, e1)), 3, 1, 1'b0);
            push_vert(lerp_vec(p0, p2, lerp_weight(e0, e2)), 3, 2, 1'b1);
         end
      end
   endtask

   always @(posedge clock) begin
      vert_type e;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready) clip_triangle(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_verts.size() == 0) begin
               $display("%0t: unexpected vertex transaction %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_verts.pop_front();
               if (e.vert_x !== rsp_data.vert_x || e.vert_y !== rsp_data.vert_y
                     || e.vert_z !== rsp_data.vert_z
                     || e.vertex_count !== rsp_data.vertex_count
                     || e.vertex_slot !== rsp_data.vertex_slot
                     || e.present !== rsp_data.present || e.last !== rsp_data.last) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h cnt=%0d slot=%0d p=%b l=%b",
                           $time, e.vert_x, e.vert_y, e.vert_z, e.vertex_count,
                           e.vertex_slot, e.present, e.last);
                  $display("%0t:          actual x=%h y=%h z=%h cnt=%0d slot=%0d p=%b l=%b",
                           $time, rsp_data.vert_x, rsp_data.vert_y, rsp_data.vert_z,
                           rsp_data.vertex_count, rsp_data.vertex_slot, rsp_data.present,
                           rsp_data.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_verts.size();
      end
   end

endmodule

[dv/tb_triangle_plane_clipper_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_plane_clipper_core
// Drives directed and random triangles with random gaps and vertex stalls;
// the checker predicts and compares every vertex transaction.
// ----------------------------------------------------------------------------
module tb_triangle_plane_clipper_core;
   import tpc_pkg::*;

   localparam int Latency = 25;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   stim_done;

   tpc_if #(.payload_type(tri_type))  req_if ();
   tpc_if #(.payload_type(vert_type)) rsp_if ();

   triangle_plane_clipper_core DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   tpc_monitor checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_data      (req_if.data),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_data      (rsp_if.data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic coord_type rand_coord(int kind);
      case (kind)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         2: return coord_type'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: return coord_type'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      endcase
   endfunction

   function automatic vec_type rand_vec(int kind);
      vec_type v;
      v.x = rand_coord(kind);
      v.y = rand_coord(kind);
      v.z = rand_coord(kind);
      return v;
   endfunction

   function automatic vec_type mk_vec(coord_type x, coord_type y, coord_type z);
      vec_type v;
      v.x = x; v.y = y; v.z = z;
      return v;
   endfunction

   function automatic tri_type mk_tri(vec_type n, vec_type a, vec_type b, vec_type c);
      tri_type t;
      t.n = n; t.v0 = a; t.v1 = b; t.v2 = c;
      return t;
   endfunction

   task automatic send_triangle(tri_type t);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= t;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   initial begin
      tri_type t;
      vec_type up;
      coord_type mx, mn;
      int kind;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      stim_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      mx = 32'sh7fff_ffff;
      mn = 32'sh8000_0000;
      up = mk_vec(0, 0, 32'sh0001_0000);
      // all below / near plane: empty
      send_triangle(mk_tri(up, mk_vec(0, 0, 0), mk_vec(1, 1, 0), mk_vec(5, 5, 0)));
      send_triangle(mk_tri(up, mk_vec(0, 0, -65536), mk_vec(0, 0, -2), mk_vec(0, 0, 654)));
      // distance just at the threshold
      send_triangle(mk_tri(up, mk_vec(0, 0, 655), mk_vec(0, 0, 0), mk_vec(0, 0, -1)));
      send_triangle(mk_tri(up, mk_vec(0, 0, 655), mk_vec(0, 0, 0), mk_vec(0, 0, -2)));
      // pass through
      send_triangle(mk_tri(up, mk_vec(mx, mn, 32'sh10000), mk_vec(mn, mx, 32'sh20000),
                           mk_vec(1, 2, 32'sh30000)));
      // one vertex below in each position
      send_triangle(mk_tri(up, mk_vec(0, 0, -32'sh10000), mk_vec(32'sh10000, 0, 32'sh10000),
                           mk_vec(0, 32'sh10000, 32'sh20000)));
      send_triangle(mk_tri(up, mk_vec(0, 0, 32'sh10000), mk_vec(32'sh10000, 0, -32'sh10000),
                           mk_vec(0, 32'sh10000, 32'sh20000)));
      send_triangle(mk_tri(up, mk_vec(0, 0, 32'sh10000), mk_vec(32'sh10000, 0, 32'sh10000),
                           mk_vec(0, 32'sh10000, -32'sh20000)));
      // two vertices below in each position
      send_triangle(mk_tri(up, mk_vec(0, 0, 32'sh10000), mk_vec(32'sh10000, 0, -32'sh10000),
                           mk_vec(0, 32'sh10000, -32'sh20000)));
      send_triangle(mk_tri(up, mk_vec(0, 0, -32'sh10000), mk_vec(32'sh10000, 0, 32'sh10000),
                           mk_vec(0, 32'sh10000, -32'sh20000)));
      send_triangle(mk_tri(up, mk_vec(mn, mx, -32'sh10000), mk_vec(mx, mn, -32'sh10000),
                           mk_vec(mx, mx, 32'sh30000)));
      // saturating distances
      send_triangle(mk_tri(mk_vec(mx, mx, mx), mk_vec(mx, mx, mx), mk_vec(mn, mn, mn),
                           mk_vec(mx, mn, 0)));
      send_triangle(mk_tri(mk_vec(mn, mn, mn), mk_vec(mn, mn, mn), mk_vec(mx, mx, mx),
                           mk_vec(mn, mx, mn)));
      send_triangle(mk_tri(mk_vec(mn, mn, mn), mk_vec(mx, mx, mx), mk_vec(mn, mn, mn),
                           mk_vec(-1, -1, -1)));
      send_triangle(mk_tri(mk_vec(-1, -1, -1), mk_vec(-1, -1, -1), mk_vec(-1, -1, -1),
                           mk_vec(-1, -1, -1)));
      for (int i = 0; i < 120; i++) begin
         kind = $urandom_range(0, 3);
         t = mk_tri(rand_vec(kind), rand_vec(kind), rand_vec(kind), rand_vec(kind));
         if ($urandom_range(0, 2) != 0)
            t.n = mk_vec(rand_coord(3), rand_coord(3), rand_coord(3));
         send_triangle(t);
      end
      req_if.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            gap = $urandom_range(0, 9);
            if (gap != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (Latency * 2) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS triangle_plane_clipper_core");
      else
         $display("FAIL triangle_plane_clipper_core");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL triangle_plane_clipper_core");
      $finish;
   end

endmodule
